### hw/rtl/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_DIV   = 3'd4;
   localparam logic [2:0] OP_PRINT = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_ZDIV  = 2'd3;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam int DIV_STEPS = 48;
   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CLS_PUSH  = 3'd0,
      CLS_ADD   = 3'd1,
      CLS_SUB   = 3'd2,
      CLS_MUL   = 3'd3,
      CLS_DIV   = 3'd4,
      CLS_PRINT = 3'd5,
      CLS_NOP   = 3'd6
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic signed [31:0] value;
   } cmd_type;

endpackage

### hw/rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rpn_div.sv
// Serial restoring Q16.16 divider, one quotient bit per cycle, with saturation.
`timescale 1ns / 1ps

module rpn_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   import rpn_pkg::*;

   localparam int CW = $clog2(DIV_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [47:0]   num_ff, num_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;

   logic [32:0]   shifted;
   logic [32:0]   diff;
   logic          ge;
   logic [31:0]   mag_a;
   logic [31:0]   mag_b;

   assign mag_a   = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign mag_b   = divisor[31] ? (~divisor + 32'd1) : divisor;
   assign shifted = {rem_ff, num_ff[47]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = !diff[32];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_STEPS - 1);
         num_in  = {mag_a, 16'd0};
         rem_in  = '0;
         den_in  = mag_b;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         num_in = {num_ff[46:0], ge};
         rem_in = ge ? diff[31:0] : shifted[31:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         quotient = (num_ff > 48'h0000_8000_0000) ? Q_MIN : -$signed(num_ff[31:0]);
      end else begin
         quotient = (num_ff > 48'h0000_7FFF_FFFF) ? Q_MAX : $signed(num_ff[31:0]);
      end
   end

   assign done = done_ff;

endmodule

### hw/rtl/rpn_front.sv
// Front end: accepts request items and decodes the operation into a command.
`timescale 1ns / 1ps

module rpn_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output rpn_pkg::cmd_type   cmd
);

   import rpn_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cls_type cls;

   always_comb begin
      unique case (req_operation)
         OP_PUSH:  cls = CLS_PUSH;
         OP_ADD:   cls = CLS_ADD;
         OP_SUB:   cls = CLS_SUB;
         OP_MUL:   cls = CLS_MUL;
         OP_DIV:   cls = CLS_DIV;
         OP_PRINT: cls = CLS_PRINT;
         default:  cls = CLS_NOP;
      endcase
   end

   assign req_ready = !valid_ff || cmd_ready;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (req_valid && req_ready) begin
         valid_in     = 1'b1;
         cmd_in.cls   = cls;
         cmd_in.value = (cls == CLS_PUSH) ? req_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

### hw/rtl/rpn_cmd_fifo.sv
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module rpn_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpn_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output rpn_pkg::cmd_type out_cmd
);

   import rpn_pkg::*;

   localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type       entry_ff [CMD_QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign in_ready  = count_ff != NW'(CMD_QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= in_cmd;
      end
   end

endmodule

### hw/rtl/rpn_back.sv
// Execution unit: value stack, saturating arithmetic and the result register.
`timescale 1ns / 1ps

module rpn_back #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  rpn_pkg::cmd_type   cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_printed,
   output logic [7:0]         rsp_depth_now
);

   import rpn_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_MUL   = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   cls_type            cls_ff, cls_in;
   logic signed [31:0] val_ff, val_in;
   logic [SW-1:0]      sp_ff, sp_in;
   logic signed [31:0] tos_ff, tos_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0]         status_ff, status_in;
   logic               printed_ff, printed_in;
   logic signed [31:0] pval_ff, pval_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_printed_ff, rsp_printed_in;
   logic [7:0]         rsp_depth_ff, rsp_depth_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [31:0]        ram_rdata;

   logic               div_start;
   logic               div_done;
   logic signed [31:0] div_quo;

   logic               has1;
   logic               has2;
   logic signed [31:0] right_op;
   logic signed [31:0] left_op;
   logic [32:0]        sum;
   logic [32:0]        dif;
   logic signed [31:0] add_sat;
   logic signed [31:0] sub_sat;
   logic signed [31:0] mul_sat;
   logic [AW-1:0]      bin_addr;
   logic [SW-1:0]      bin_sp;
   logic               commit;
   logic signed [31:0] bin_val;

   assign has1     = sp_ff != '0;
   assign has2     = sp_ff > SW'(1);
   assign right_op = has1 ? tos_ff : '0;
   assign left_op  = has2 ? $signed(ram_rdata) : '0;
   assign ram_raddr = AW'(sp_ff - SW'(2));
   assign bin_addr = has2 ? AW'(sp_ff - SW'(2)) : '0;
   assign bin_sp   = has2 ? sp_ff - SW'(1) : SW'(1);

   assign sum     = {left_op[31], left_op} + {right_op[31], right_op};
   assign dif     = {left_op[31], left_op} - {right_op[31], right_op};
   assign add_sat = (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : $signed(sum[31:0]);
   assign sub_sat = (dif[32] != dif[31]) ? (dif[32] ? Q_MIN : Q_MAX) : $signed(dif[31:0]);
   assign mul_sat = (prod_ff[63:47] != {17{prod_ff[63]}}) ?
                    (prod_ff[63] ? Q_MIN : Q_MAX) : prod_ff[47:16];
   assign prod_in = 64'(left_op) * 64'(right_op);

   assign cmd_ready = state_ff == S_IDLE;

   always_comb begin
      state_in       = state_ff;
      cls_in         = cls_ff;
      val_in         = val_ff;
      sp_in          = sp_ff;
      tos_in         = tos_ff;
      status_in      = status_ff;
      printed_in     = printed_ff;
      pval_in        = pval_ff;
      ram_we         = 1'b0;
      ram_waddr      = AW'(sp_ff);
      ram_wdata      = val_ff;
      div_start      = 1'b0;
      commit         = 1'b0;
      bin_val        = add_sat;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_printed_in = rsp_printed_ff;
      rsp_depth_in   = rsp_depth_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cls_in     = cmd.cls;
               val_in     = cmd.value;
               status_in  = ST_OK;
               printed_in = 1'b0;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_DONE;
            case (cls_ff)
               CLS_PUSH: begin
                  if (sp_ff < SW'(DEPTH)) begin
                     ram_we = 1'b1;
                     tos_in = val_ff;
                     sp_in  = sp_ff + SW'(1);
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               CLS_ADD: begin
                  commit  = 1'b1;
                  bin_val = add_sat;
               end
               CLS_SUB: begin
                  commit  = 1'b1;
                  bin_val = sub_sat;
               end
               CLS_MUL: begin
                  state_in = S_MUL;
               end
               CLS_DIV: begin
                  if (right_op == '0) begin
                     if (has1) begin
                        status_in = ST_ZDIV;
                        sp_in     = sp_ff - SW'(1);
                        tos_in    = $signed(ram_rdata);
                     end else begin
                        status_in = ST_EMPTY;
                     end
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               CLS_PRINT: begin
                  printed_in = 1'b1;
                  pval_in    = right_op;
                  if (has1) begin
                     sp_in  = sp_ff - SW'(1);
                     tos_in = $signed(ram_rdata);
                  end else begin
                     status_in = ST_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MUL: begin
            commit   = 1'b1;
            bin_val  = mul_sat;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               commit   = 1'b1;
               bin_val  = div_quo;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = printed_ff ? pval_ff : (has1 ? tos_ff : '0);
               rsp_status_in  = status_ff;
               rsp_printed_in = printed_ff;
               rsp_depth_in   = 8'(sp_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (commit) begin
         ram_we    = 1'b1;
         ram_waddr = bin_addr;
         ram_wdata = bin_val;
         tos_in    = bin_val;
         sp_in     = bin_sp;
         status_in = has2 ? ST_OK : ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_ff         <= cls_in;
      val_ff         <= val_in;
      tos_ff         <= tos_in;
      prod_ff        <= prod_in;
      status_ff      <= status_in;
      printed_ff     <= printed_in;
      pval_ff        <= pval_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_printed_ff <= rsp_printed_in;
      rsp_depth_ff   <= rsp_depth_in;
   end

   rpn_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   rpn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(left_op),
      .divisor (right_op),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_printed      = rsp_printed_ff;
   assign rsp_depth_now    = rsp_depth_ff;

endmodule

### hw/rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: decode front end, command queue, execution unit.
// A request passes the front-end register, the command queue and the FETCH and DONE
// states of the execution unit; multiply adds the MUL state, and divide waits in DIV for
// the 48-step serial divider. The execution unit takes a new item only from IDLE and waits
// in DONE for a free result register; the front end and two-entry queue accept until full.
// Reset empties the stack, the queue and the result register; stack memory is not cleared.
`timescale 1ns / 1ps

module rpn_stack_calculator #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_printed,
   output logic [7:0]         rsp_depth_now
);

   import rpn_pkg::*;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    queue_valid;
   logic    queue_ready;
   cmd_type queue_cmd;

   rpn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_value    (req_value),
      .cmd_valid    (front_valid),
      .cmd_ready    (front_ready),
      .cmd          (front_cmd)
   );

   rpn_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_cmd   (front_cmd),
      .out_valid(queue_valid),
      .out_ready(queue_ready),
      .out_cmd  (queue_cmd)
   );

   rpn_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (queue_valid),
      .cmd_ready       (queue_ready),
      .cmd             (queue_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_status      (rsp_status),
      .rsp_printed     (rsp_printed),
      .rsp_depth_now   (rsp_depth_now)
   );

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_depth_now) <= DEPTH))
      else $error("reported stack depth exceeds the stack size");

   a_print_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_printed) |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY))
      else $error("printed item carries a full or divide status");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (DEPTH < 256 && rsp_valid && !rsp_printed && rsp_depth_now == 8'd0)
      |-> (rsp_result_value == 32'sd0))
      else $error("empty stack reports a nonzero top value");

   a_full_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (32'(rsp_depth_now) == (DEPTH % 256)))
      else $error("full status reported while the stack is not full");

endmodule
